FILE: sv/drive_and_heading_hold_pwm_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the drive and heading hold PWM block
// Both macros sample on clk and stay quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DRIVE_AND_HEADING_HOLD_PWM_MACROS_SVH
`define DRIVE_AND_HEADING_HOLD_PWM_MACROS_SVH

// Check cons in the same cycle as ante
`define DHH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define DHH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dhh_pkg.sv
// ---------------------------------------------------------------------------
// dhh_pkg
// Shared types, register indexes and arithmetic constants for the drive and
// heading hold PWM block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhh_pkg;

    // Port widths
    localparam int LEVEL_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Shared multiplier widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEER_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_GAIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEER_THR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KP         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_CAP  = 3'd5;

    // Register reset values
    localparam logic [7:0]  RST_STEER_GAIN = 8'd16;
    localparam logic [9:0]  RST_SPEED_GAIN = 10'd516;
    localparam logic [6:0]  RST_STEER_THR  = 7'd10;
    localparam logic [15:0] RST_KP         = 16'd256;
    localparam logic [7:0]  RST_ERROR_CAP  = 8'd30;

    // Item kinds
    localparam logic ACT_MOVE = 1'b0;
    localparam logic ACT_YAW  = 1'b1;

    // Steer scaling: round a 1/16 product and clamp to 127
    localparam logic [15:0] STEER_ROUND = 16'd8;
    localparam logic [11:0] STEER_LIMIT = 12'd127;

    // Heading error in centidegrees
    localparam logic [15:0]        QUARTER_TURN = 16'd9000;
    localparam logic signed [18:0] FULL_TURN    = 19'sd36000;
    localparam logic [16:0]        DEG_ROUND    = 17'd50;
    localparam logic [16:0]        DEG_DIV      = 17'd100;

    // Divide by 100 as x * 5242 >> 19; the estimate is low by at most one
    localparam logic [12:0] DEG_RECIP = 13'd5242;
    localparam int          DEG_SHIFT = 19;
    localparam int          DEG_W     = 10;

    // Round the 8.8 hold gain product
    localparam logic [26:0] HOLD_ROUND = 27'd128;

    // Datapath operation for one sequencing step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_STEER_GAIN,
        OP_DRIVE_LEVEL,
        OP_STEER_LEVEL,
        OP_ERR_RECIP,
        OP_ERR_DEG,
        OP_HOLD_GAIN
    } dhh_op_t;

    // How the end of a request updates the state
    typedef enum logic [1:0] {
        KIND_KEEP,
        KIND_MOVE,
        KIND_YAW
    } dhh_kind_t;

    typedef struct packed {
        logic      load;
        dhh_op_t   op;
        logic      commit;
        dhh_kind_t kind;
    } dhh_cmd_t;

    typedef struct packed {
        logic item_yaw;
        logic enabled;
        logic out_free;
    } dhh_status_t;

    typedef struct packed {
        logic               action;
        logic signed [7:0]  steer_cmd;
        logic signed [7:0]  drive_cmd;
        logic               script_mode;
        logic signed [15:0] heading;
    } dhh_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] drive_fwd_level;
        logic [LEVEL_W-1:0] drive_rev_level;
        logic [LEVEL_W-1:0] steer_left_level;
        logic [LEVEL_W-1:0] steer_right_level;
        logic               hold_on;
    } dhh_out_t;

endpackage

FILE: sv/drive_and_heading_hold_pwm.sv
// ---------------------------------------------------------------------------
// drive_and_heading_hold_pwm
// Flow: an accepted request runs three datapath steps, which share the one
// multiplier, then a commit; no new request is taken until that commit, which
// waits while a stalled result still holds the output register.
// Reset: all PWM levels, hold state and headings clear; registers take their
// defaults with the block disabled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_and_heading_hold_pwm #(
    parameter int LEVEL_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  dhh_pkg::dhh_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output dhh_pkg::dhh_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [dhh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dhh_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dhh_pkg::dhh_cmd_t    cmd;
    dhh_pkg::dhh_status_t status;

    // Sequencer
    dhh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and state
    dhh_datapath #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: sv/dhh_ctrl.sv
// ---------------------------------------------------------------------------
// dhh_ctrl
// Sequencer: accepts one request, runs three datapath steps (a yaw item's
// second is no multiply) and commits the result when the output register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhh_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dhh_pkg::dhh_status_t status,
    output dhh_pkg::dhh_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_A,
        ST_STEP_B,
        ST_STEP_C,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   stall_reg;

    // Decode the step into a datapath command
    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.op     = dhh_pkg::OP_NONE;
        cmd.commit = 1'b0;
        if (!status.enabled)
        begin
            cmd.kind = dhh_pkg::KIND_KEEP;
        end
        else if (status.item_yaw)
        begin
            cmd.kind = dhh_pkg::KIND_YAW;
        end
        else
        begin
            cmd.kind = dhh_pkg::KIND_MOVE;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_STEP_A:
            begin
                cmd.op = status.item_yaw ? dhh_pkg::OP_ERR_RECIP : dhh_pkg::OP_STEER_GAIN;
            end
            ST_STEP_B:
            begin
                cmd.op = status.item_yaw ? dhh_pkg::OP_ERR_DEG : dhh_pkg::OP_DRIVE_LEVEL;
            end
            ST_STEP_C:
            begin
                cmd.op = status.item_yaw ? dhh_pkg::OP_HOLD_GAIN : dhh_pkg::OP_STEER_LEVEL;
            end
            ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    // Advance the sequence; stall the input from accept to commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_STEP_A;
                        stall_reg <= 1'b1;
                    end
                end
                ST_STEP_A:
                begin
                    state_reg <= ST_STEP_B;
                end
                ST_STEP_B:
                begin
                    state_reg <= ST_STEP_C;
                end
                ST_STEP_C:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                        stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    stall_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_stall = stall_reg;

endmodule

FILE: sv/dhh_datapath.sv
// ---------------------------------------------------------------------------
// dhh_datapath
// Configuration registers, PWM state, one shared 17x16 multiplier, heading
// error arithmetic and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhh_datapath #(
    parameter int LEVEL_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dhh_pkg::dhh_cmd_t                   cmd,
    output dhh_pkg::dhh_status_t                status,
    input  dhh_pkg::dhh_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output dhh_pkg::dhh_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [dhh_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dhh_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int PROD_W = dhh_pkg::PROD_W;
    localparam int DEG_W  = dhh_pkg::DEG_W;

    // Clamp a product to the largest PWM level
    function automatic logic [LEVEL_BITS-1:0] sat_level(input logic [PROD_W-1:0] v);
        logic over;
        over = |(v >> LEVEL_BITS);
        return over ? {LEVEL_BITS{1'b1}} : v[LEVEL_BITS-1:0];
    endfunction

    // Configuration
    logic        enabled_reg;
    logic [7:0]  steer_gain_reg;
    logic [9:0]  speed_gain_reg;
    logic [6:0]  steer_thr_reg;
    logic [15:0] kp_reg;
    logic [7:0]  error_cap_reg;

    // Block state
    logic [LEVEL_BITS-1:0] fwd_level_reg,   fwd_level_next;
    logic [LEVEL_BITS-1:0] rev_level_reg,   rev_level_next;
    logic [LEVEL_BITS-1:0] left_level_reg,  left_level_next;
    logic [LEVEL_BITS-1:0] right_level_reg, right_level_next;
    logic                  hold_active_reg, hold_active_next;
    logic signed [15:0]    hold_heading_reg, hold_heading_next;
    logic signed [15:0]    cur_heading_reg,  cur_heading_next;
    logic signed [7:0]     last_drive_reg,   last_drive_next;

    // Working registers
    dhh_pkg::dhh_in_t            item_reg;
    logic [PROD_W-1:0]           prod_reg, prod_next;
    logic [dhh_pkg::MUL_A_W-1:0] mul_a;
    logic [dhh_pkg::MUL_B_W-1:0] mul_b;
    logic                        mul_en;
    logic [7:0]                  s_mag_reg;
    logic [LEVEL_BITS-1:0]       drive_lv_reg;
    logic [16:0]                 x_reg;
    logic [DEG_W-1:0]            deg_reg;
    logic                        out_valid_reg;
    dhh_pkg::dhh_out_t           out_data_reg;

    // Command magnitudes
    logic       steer_neg, drive_neg, drive_zero;
    logic [7:0] steer_abs, drive_abs;
    logic [15:0] steer_sum;
    logic [11:0] steer_round;
    logic [7:0]  s_eff_mag;

    // Heading error
    logic [15:0]        ay, ar;
    logic signed [18:0] y_ext, r_ext, ay_ext, ar_ext;
    logic signed [18:0] e_same, e_opp, e_wrap, e_direct, e_val;
    logic [18:0]        e_abs_full;
    logic               y_pos, r_pos, same_sign, big_y, big_r;
    logic [16:0]        x_next;
    logic [DEG_W-1:0]   q0, deg_raw, deg_capped;
    logic [16:0]        q0_x100, rem;
    logic [26:0]        hold_sum;
    logic [LEVEL_BITS-1:0] hold_lv, prod_lv;

    assign steer_neg  = item_reg.steer_cmd[7];
    assign drive_neg  = item_reg.drive_cmd[7];
    assign drive_zero = (item_reg.drive_cmd == 8'sd0);
    assign steer_abs  = steer_neg ? (~$unsigned(item_reg.steer_cmd) + 8'd1)
                                  : $unsigned(item_reg.steer_cmd);
    assign drive_abs  = drive_neg ? (~$unsigned(item_reg.drive_cmd) + 8'd1)
                                  : $unsigned(item_reg.drive_cmd);

    // Round |steer| * gain / 16 and clamp; script mode takes the command as is
    assign steer_sum   = {1'b0, prod_reg[14:0]} + dhh_pkg::STEER_ROUND;
    assign steer_round = steer_sum[15:4];
    assign s_eff_mag   = item_reg.script_mode ? steer_abs :
                         (steer_round > dhh_pkg::STEER_LIMIT) ? 8'(dhh_pkg::STEER_LIMIT)
                                                              : steer_round[7:0];

    // Wrap-around heading error against the held heading
    assign ay = item_reg.heading[15] ? (~$unsigned(item_reg.heading) + 16'd1)
                                     : $unsigned(item_reg.heading);
    assign ar = hold_heading_reg[15] ? (~$unsigned(hold_heading_reg) + 16'd1)
                                     : $unsigned(hold_heading_reg);
    assign y_ext    = {{3{item_reg.heading[15]}}, item_reg.heading};
    assign r_ext    = {{3{hold_heading_reg[15]}}, hold_heading_reg};
    assign ay_ext   = {3'b000, ay};
    assign ar_ext   = {3'b000, ar};
    assign y_pos    = !item_reg.heading[15] && (item_reg.heading != 16'sd0);
    assign r_pos    = !hold_heading_reg[15] && (hold_heading_reg != 16'sd0);
    assign same_sign = (y_pos && r_pos) || (item_reg.heading[15] && hold_heading_reg[15]);
    assign big_y    = ay > dhh_pkg::QUARTER_TURN;
    assign big_r    = ar > dhh_pkg::QUARTER_TURN;
    assign e_same   = ay_ext - ar_ext;
    assign e_opp    = ay_ext + ar_ext;
    assign e_wrap   = e_opp - dhh_pkg::FULL_TURN;
    assign e_direct = y_ext - r_ext;

    always_comb
    begin
        priority if (!(big_y || big_r))
        begin
            e_val = e_direct;
        end
        else if (same_sign)
        begin
            e_val = e_same;
        end
        else if (big_y && big_r)
        begin
            e_val = e_wrap;
        end
        else
        begin
            e_val = e_opp;
        end
    end

    assign e_abs_full = e_val[18] ? (~$unsigned(e_val) + 19'd1) : $unsigned(e_val);
    assign x_next     = e_abs_full[16:0] + dhh_pkg::DEG_ROUND;

    // Finish the divide by 100: fix the low estimate, then cap
    assign q0         = prod_reg[dhh_pkg::DEG_SHIFT +: DEG_W];
    assign q0_x100    = 17'(q0) * dhh_pkg::DEG_DIV;
    assign rem        = x_reg - q0_x100;
    assign deg_raw    = (rem >= dhh_pkg::DEG_DIV) ? (q0 + 10'd1) : q0;
    assign deg_capped = (deg_raw > {2'b00, error_cap_reg}) ? {2'b00, error_cap_reg} : deg_raw;

    // Levels from the product register
    assign prod_lv  = sat_level(prod_reg);
    assign hold_sum = prod_reg[26:0] + dhh_pkg::HOLD_ROUND;
    assign hold_lv  = sat_level(PROD_W'(hold_sum[26:8]));

    // Select multiplier operands
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (cmd.op)
            dhh_pkg::OP_STEER_GAIN:
            begin
                mul_a = 17'(steer_abs);
                mul_b = 16'(steer_gain_reg);
            end
            dhh_pkg::OP_DRIVE_LEVEL:
            begin
                mul_a = 17'(drive_abs);
                mul_b = 16'(speed_gain_reg);
            end
            dhh_pkg::OP_STEER_LEVEL:
            begin
                mul_a = 17'(s_mag_reg);
                mul_b = 16'(speed_gain_reg);
            end
            dhh_pkg::OP_ERR_RECIP:
            begin
                mul_a = x_next;
                mul_b = 16'(dhh_pkg::DEG_RECIP);
            end
            dhh_pkg::OP_HOLD_GAIN:
            begin
                mul_a = 17'(deg_reg);
                mul_b = kp_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Work out the state after the request
    always_comb
    begin
        fwd_level_next    = fwd_level_reg;
        rev_level_next    = rev_level_reg;
        left_level_next   = left_level_reg;
        right_level_next  = right_level_reg;
        hold_active_next  = hold_active_reg;
        hold_heading_next = hold_heading_reg;
        cur_heading_next  = cur_heading_reg;
        last_drive_next   = last_drive_reg;
        unique case (cmd.kind)
            dhh_pkg::KIND_MOVE:
            begin
                last_drive_next = item_reg.drive_cmd;
                fwd_level_next  = (!drive_neg && !drive_zero) ? drive_lv_reg : '0;
                rev_level_next  = drive_neg ? drive_lv_reg : '0;
                priority if (s_mag_reg > {1'b0, steer_thr_reg})
                begin
                    hold_active_next = 1'b0;
                    left_level_next  = steer_neg ? prod_lv : '0;
                    right_level_next = steer_neg ? '0 : prod_lv;
                end
                else if (!drive_zero)
                begin
                    hold_active_next  = 1'b1;
                    hold_heading_next = cur_heading_reg;
                end
                else
                begin
                    hold_active_next = 1'b0;
                    left_level_next  = '0;
                    right_level_next = '0;
                end
            end
            dhh_pkg::KIND_YAW:
            begin
                cur_heading_next = item_reg.heading;
                if (hold_active_reg)
                begin
                    if ((item_reg.heading < hold_heading_reg) == last_drive_reg[7])
                    begin
                        right_level_next = hold_lv;
                    end
                    else
                    begin
                        left_level_next = hold_lv;
                    end
                end
            end
            default:
            begin
                last_drive_next = last_drive_reg;
            end
        endcase
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            steer_gain_reg <= dhh_pkg::RST_STEER_GAIN;
            speed_gain_reg <= dhh_pkg::RST_SPEED_GAIN;
            steer_thr_reg  <= dhh_pkg::RST_STEER_THR;
            kp_reg         <= dhh_pkg::RST_KP;
            error_cap_reg  <= dhh_pkg::RST_ERROR_CAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dhh_pkg::CFG_ENABLED:    enabled_reg    <= cfg_data[0];
                dhh_pkg::CFG_STEER_GAIN: steer_gain_reg <= cfg_data[7:0];
                dhh_pkg::CFG_SPEED_GAIN: speed_gain_reg <= cfg_data[9:0];
                dhh_pkg::CFG_STEER_THR:  steer_thr_reg  <= cfg_data[6:0];
                dhh_pkg::CFG_KP:         kp_reg         <= cfg_data[15:0];
                dhh_pkg::CFG_ERROR_CAP:  error_cap_reg  <= cfg_data[7:0];
                default:                 enabled_reg    <= enabled_reg;
            endcase
        end
    end

    // Capture the request and step the working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.op == dhh_pkg::OP_DRIVE_LEVEL)
        begin
            s_mag_reg <= s_eff_mag;
        end
        if (cmd.op == dhh_pkg::OP_STEER_LEVEL)
        begin
            drive_lv_reg <= prod_lv;
        end
        if (cmd.op == dhh_pkg::OP_ERR_RECIP)
        begin
            x_reg <= x_next;
        end
        if (cmd.op == dhh_pkg::OP_ERR_DEG)
        begin
            deg_reg <= deg_capped;
        end
        if (cmd.commit)
        begin
            out_data_reg.drive_fwd_level   <= dhh_pkg::LEVEL_W'(fwd_level_next);
            out_data_reg.drive_rev_level   <= dhh_pkg::LEVEL_W'(rev_level_next);
            out_data_reg.steer_left_level  <= dhh_pkg::LEVEL_W'(left_level_next);
            out_data_reg.steer_right_level <= dhh_pkg::LEVEL_W'(right_level_next);
            out_data_reg.hold_on           <= hold_active_next;
        end
    end

    // Update the block state on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_level_reg    <= '0;
            rev_level_reg    <= '0;
            left_level_reg   <= '0;
            right_level_reg  <= '0;
            hold_active_reg  <= 1'b0;
            hold_heading_reg <= '0;
            cur_heading_reg  <= '0;
            last_drive_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            fwd_level_reg    <= fwd_level_next;
            rev_level_reg    <= rev_level_next;
            left_level_reg   <= left_level_next;
            right_level_reg  <= right_level_next;
            hold_active_reg  <= hold_active_next;
            hold_heading_reg <= hold_heading_next;
            cur_heading_reg  <= cur_heading_next;
            last_drive_reg   <= last_drive_next;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.item_yaw = (item_reg.action == dhh_pkg::ACT_YAW);
    assign status.enabled  = enabled_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

endmodule

FILE: sv/dhh_checker.sv
// ---------------------------------------------------------------------------
// dhh_checker
// Port-level checks for the drive and heading hold PWM block, bound to the
// top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "drive_and_heading_hold_pwm_macros.svh"

module dhh_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input dhh_pkg::dhh_out_t out_data
);

    // Hold a stalled result
    `DHH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // Block further requests while one is in work
    `DHH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request taken while busy")

    // Never raise a result right after an accept
    `DHH_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid), "result too early")

    // Never drive both sides of the drive bridge
    `DHH_ASSERT_SAME(a_drive_exclusive, out_valid, (out_data.drive_fwd_level == 16'd0) || (out_data.drive_rev_level == 16'd0), "both drive sides on")

endmodule

bind drive_and_heading_hold_pwm dhh_checker u_checker (.*);
